>>> rtl/cmsc_pkg.sv
// Shared types and constants for the millisecond calendar clock.
// Used by cmsc_uptime_mac and calendar_ms_clock_with_uptime; no dependencies.
package cmsc_pkg;

  localparam int UPTIME_W = 48;

  typedef logic [UPTIME_W-1:0] uptime_t;
  typedef logic [2:0]          step_t;

  // Horner steps of the uptime sum: year first, then one step per field
  localparam step_t STEP_FIRST  = 3'd1;
  localparam step_t STEP_DAY    = 3'd2;
  localparam step_t STEP_HOUR   = 3'd3;
  localparam step_t STEP_MINUTE = 3'd4;
  localparam step_t STEP_SECOND = 3'd5;
  localparam step_t STEP_MS     = 3'd6;

  // clock field minus boot field, one bit wider, two's complement
  typedef struct packed {
    logic [8:0] year;
    logic [4:0] month;
    logic [5:0] day;
    logic [5:0] hour;
    logic [6:0] minute;
    logic [6:0] second;
  } diff_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mac_status_t;

  typedef struct packed {
    logic [7:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } boot_t;

  // factor that scales the running sum at each step up to the seconds step; 0 for any other
  function automatic logic [9:0] mac_factor(input step_t step);
    case (step)
      STEP_FIRST:  mac_factor = 10'd12;
      STEP_DAY:    mac_factor = 10'd30;
      STEP_HOUR:   mac_factor = 10'd24;
      STEP_MINUTE: mac_factor = 10'd60;
      STEP_SECOND: mac_factor = 10'd60;
      default:     mac_factor = 10'd0;
    endcase
  endfunction

endpackage

>>> rtl/cmsc_uptime_mac.sv
// Iterative multiply-add unit for the uptime: sum = diff + sum * factor, one step a cycle.
// Depends on cmsc_pkg.
module cmsc_uptime_mac #(
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  cmsc_pkg::diff_t        diff,
  input  logic [9:0]             ms,
  output cmsc_pkg::mac_status_t  status,
  output cmsc_pkg::uptime_t      seconds,
  output cmsc_pkg::uptime_t      ms_total
);

  localparam logic [9:0] TPS = 10'(TICKS_PER_SECOND);

  cmsc_pkg::step_t   step;
  cmsc_pkg::uptime_t acc;
  cmsc_pkg::uptime_t addend;
  cmsc_pkg::uptime_t prod;
  logic [9:0]        factor;
  logic              busy;
  logic              done;

  assign factor = (step == cmsc_pkg::STEP_MS) ? TPS : cmsc_pkg::mac_factor(step);
  assign prod   = acc * cmsc_pkg::UPTIME_W'(factor);

  always_comb begin
    case (step)
      cmsc_pkg::STEP_FIRST:  addend = {{43{diff.month[4]}}, diff.month};
      cmsc_pkg::STEP_DAY:    addend = {{42{diff.day[5]}}, diff.day};
      cmsc_pkg::STEP_HOUR:   addend = {{42{diff.hour[5]}}, diff.hour};
      cmsc_pkg::STEP_MINUTE: addend = {{41{diff.minute[6]}}, diff.minute};
      cmsc_pkg::STEP_SECOND: addend = {{41{diff.second[6]}}, diff.second};
      default:               addend = {38'd0, ms};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      acc  <= {{39{diff.year[8]}}, diff.year};
      step <= cmsc_pkg::STEP_FIRST;
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      if (step == cmsc_pkg::STEP_MS) begin
        ms_total <= prod + addend;
        busy     <= 1'b0;
        done     <= 1'b1;
      end else begin
        acc  <= prod + addend;
        step <= step + 3'd1;
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign seconds     = acc;

endmodule

>>> rtl/calendar_ms_clock_with_uptime.sv
// Millisecond calendar clock with Gregorian carry and uptime since boot.
// Depends on cmsc_pkg and cmsc_uptime_mac.
//
//   channel | handshake            | payload
//   in      | in_valid / in_ready  | func, load_year .. load_millisecond
//   out     | out_valid / out_ready| now_year .. now_millisecond, uptime_seconds, uptime_ms
//
// The clock updates at acceptance, the multiply-add unit is loaded in the next cycle and
// runs six steps of the uptime sum; the result is registered once the unit is done and the
// output is free, and the next request is taken the cycle after.
// rst is synchronous and clears the clock, the boot record and all control.
// A stalled output holds; the next request can run while it waits.
module calendar_ms_clock_with_uptime #(
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic [7:0]         load_year,
  input  logic [3:0]         load_month,
  input  logic [4:0]         load_day,
  input  logic [4:0]         load_hour,
  input  logic [5:0]         load_minute,
  input  logic [5:0]         load_second,
  input  logic [9:0]         load_millisecond,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         now_year,
  output logic [3:0]         now_month,
  output logic [4:0]         now_day,
  output logic [4:0]         now_hour,
  output logic [5:0]         now_minute,
  output logic [5:0]         now_second,
  output logic [9:0]         now_millisecond,
  output logic signed [47:0] uptime_seconds,
  output logic signed [47:0] uptime_ms
);

  localparam logic [9:0] TPS = 10'(TICKS_PER_SECOND);

  typedef enum logic [1:0] {IDLE, START, RUN} state_t;

  state_t                state;
  cmsc_pkg::boot_t       boot;
  cmsc_pkg::diff_t       diff;
  cmsc_pkg::mac_status_t mac_status;
  cmsc_pkg::uptime_t     mac_seconds;
  cmsc_pkg::uptime_t     mac_ms;

  logic [7:0] cur_year;
  logic [3:0] cur_month;
  logic [4:0] cur_day;
  logic [4:0] cur_hour;
  logic [5:0] cur_minute;
  logic [5:0] cur_second;
  logic [9:0] cur_millisecond;

  logic [7:0] year_next;
  logic [3:0] month_next;
  logic [4:0] day_next;
  logic [4:0] hour_next;
  logic [5:0] minute_next;
  logic [5:0] second_next;
  logic [9:0] millisecond_next;

  logic [9:0] ms_inc;
  logic [6:0] sec_inc;
  logic [6:0] min_inc;
  logic [5:0] hour_inc;
  logic [5:0] day_inc;
  logic [4:0] month_inc;
  logic [5:0] month_len;
  logic       leap;
  logic       accept;
  logic       out_free;
  logic       out_load;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == IDLE);
  assign out_free = !out_valid || out_ready;
  assign out_load = (state == RUN) && mac_status.done && out_free;

  assign leap = (cur_year[1:0] == 2'd0) && (cur_year != 8'd100) && (cur_year != 8'd200);

  always_comb begin
    case (cur_month)
      4'd2:    month_len = leap ? 6'd29 : 6'd28;
      4'd4:    month_len = 6'd30;
      4'd6:    month_len = 6'd30;
      4'd9:    month_len = 6'd30;
      4'd11:   month_len = 6'd30;
      default: month_len = 6'd31;
    endcase
  end

  assign ms_inc    = cur_millisecond + 10'd1;
  assign sec_inc   = {1'b0, cur_second} + 7'd1;
  assign min_inc   = {1'b0, cur_minute} + 7'd1;
  assign hour_inc  = {1'b0, cur_hour} + 6'd1;
  assign day_inc   = {1'b0, cur_day} + 6'd1;
  assign month_inc = {1'b0, cur_month} + 5'd1;

  // carry chain for one millisecond
  always_comb begin
    year_next        = cur_year;
    month_next       = cur_month;
    day_next         = cur_day;
    hour_next        = cur_hour;
    minute_next      = cur_minute;
    second_next      = cur_second;
    millisecond_next = ms_inc;
    if (ms_inc >= TPS) begin
      millisecond_next = '0;
      second_next      = sec_inc[5:0];
      if (sec_inc >= 7'd60) begin
        second_next = '0;
        minute_next = min_inc[5:0];
        if (min_inc >= 7'd60) begin
          minute_next = '0;
          hour_next   = hour_inc[4:0];
          if (hour_inc >= 6'd24) begin
            hour_next = '0;
            day_next  = day_inc[4:0];
            if (day_inc > month_len) begin
              day_next   = 5'd1;
              month_next = month_inc[3:0];
              if (month_inc > 5'd12) begin
                month_next = 4'd1;
                year_next  = cur_year + 8'd1;
              end
            end
          end
        end
      end
    end
  end

  assign diff.year   = {1'b0, cur_year} - {1'b0, boot.year};
  assign diff.month  = {1'b0, cur_month} - {1'b0, boot.month};
  assign diff.day    = {1'b0, cur_day} - {1'b0, boot.day};
  assign diff.hour   = {1'b0, cur_hour} - {1'b0, boot.hour};
  assign diff.minute = {1'b0, cur_minute} - {1'b0, boot.minute};
  assign diff.second = {1'b0, cur_second} - {1'b0, boot.second};

  cmsc_uptime_mac #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .start    (state == START),
    .diff     (diff),
    .ms       (cur_millisecond),
    .status   (mac_status),
    .seconds  (mac_seconds),
    .ms_total (mac_ms)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= IDLE;
      out_valid       <= 1'b0;
      boot            <= '0;
      cur_year        <= '0;
      cur_month       <= '0;
      cur_day         <= '0;
      cur_hour        <= '0;
      cur_minute      <= '0;
      cur_second      <= '0;
      cur_millisecond <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            if (func) begin
              cur_year        <= load_year;
              cur_month       <= load_month;
              cur_day         <= load_day;
              cur_hour        <= load_hour;
              cur_minute      <= load_minute;
              cur_second      <= load_second;
              cur_millisecond <= load_millisecond;
              boot            <= {load_year, load_month, load_day, load_hour,
                                  load_minute, load_second};
            end else begin
              cur_year        <= year_next;
              cur_month       <= month_next;
              cur_day         <= day_next;
              cur_hour        <= hour_next;
              cur_minute      <= minute_next;
              cur_second      <= second_next;
              cur_millisecond <= millisecond_next;
            end
            state <= START;
          end
        end
        START: begin
          state <= RUN;
        end
        RUN: begin
          if (out_load) begin
            now_year        <= cur_year;
            now_month       <= cur_month;
            now_day         <= cur_day;
            now_hour        <= cur_hour;
            now_minute      <= cur_minute;
            now_second      <= cur_second;
            now_millisecond <= cur_millisecond;
            uptime_seconds  <= mac_seconds;
            uptime_ms       <= mac_ms;
            state           <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_load_copies: assert property (@(posedge clk) disable iff (rst)
    (accept && func) |=> (cur_millisecond == $past(load_millisecond)) &&
                         (boot.second == $past(load_second)))
    else $error("load did not reach clock and boot record");

  a_clock_frozen: assert property (@(posedge clk) disable iff (rst)
    (state != IDLE) |=> $stable({cur_year, cur_month, cur_day, cur_hour,
                                 cur_minute, cur_second, cur_millisecond}))
    else $error("clock changed while uptime was being computed");

  a_mac_idle: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE) |-> !mac_status.busy)
    else $error("multiply-add unit busy with no request in flight");
`endif

endmodule
